@@ src/prf_pkg.sv @@
`timescale 1ns / 1ps
// shared types, constants and degree helpers for the prufer code block
// no dependencies
package prf_pkg;

    localparam int IDX_W         = 6;
    localparam int NODE_SLOTS    = 1 << IDX_W;
    localparam int DEG_W         = 7;
    localparam int MAX_NODES_DEF = 64;

    localparam logic [DEG_W-1:0] DEG_MAX = {DEG_W{1'b1}};

    typedef struct packed {
        logic [IDX_W-1:0] parent_index;
        logic             is_root;
        logic             last_node;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] code_entry;
        logic             last_entry;
    } out_item_t;

    typedef struct packed {
        logic             clr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [DEG_W-1:0] wr_data;
    } deg_req_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] wr_data;
    } par_req_t;

    function automatic logic [DEG_W-1:0] deg_inc(input logic [DEG_W-1:0] d);
        return (d == DEG_MAX) ? d : d + DEG_W'(1);
    endfunction

    function automatic logic [DEG_W-1:0] deg_dec(input logic [DEG_W-1:0] d);
        return (d == '0) ? d : d - DEG_W'(1);
    endfunction

endpackage

@@ src/prufer_code_from_parent_array_top.sv @@
`timescale 1ns / 1ps
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    in_item_t  (parent_index, is_root, last_node)
// m_       out  m_valid/m_ready    out_item_t (code_entry, last_entry)
//
// loading is paced by the two read-modify-writes of the degree ram per node
// emission of N-1 entries runs the leaf scan and the read, check, parent and output states per entry
// reset is synchronous and clears the degree valid bits at once, no clearing pass
// no request is taken while code entries are pending; a stalled m_ready holds the sequencer
// top level of the prufer code block; depends on prf_pkg, prf_ctrl, prf_deg_ram, prf_par_ram
module prufer_code_from_parent_array_top
    import prf_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    deg_req_t         deg_req;
    par_req_t         par_req;
    logic [DEG_W-1:0] deg_rd;
    logic [IDX_W-1:0] par_rd;

    prf_ctrl #(
        .MAX_NODES(MAX_NODES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .deg_req (deg_req),
        .deg_rd  (deg_rd),
        .par_req (par_req),
        .par_rd  (par_rd)
    );

    prf_deg_ram u_deg_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (deg_req),
        .rd_data (deg_rd)
    );

    prf_par_ram u_par_ram (
        .aclk    (aclk),
        .req     (par_req),
        .rd_data (par_rd)
    );

endmodule

@@ src/prf_deg_ram.sv @@
`timescale 1ns / 1ps
// degree store: synchronous ram with per-entry valid bits and write bypass
// depends on prf_pkg
module prf_deg_ram
    import prf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  deg_req_t         req,
    output logic [DEG_W-1:0] rd_data
);

    logic [DEG_W-1:0]      mem [NODE_SLOTS];
    logic [NODE_SLOTS-1:0] vld_reg;
    logic [DEG_W-1:0]      q_reg;
    logic                  qv_reg;
    logic                  byp_hit_reg;
    logic [DEG_W-1:0]      byp_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg        <= mem[req.rd_addr];
            byp_data_reg <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            qv_reg      <= 1'b0;
            byp_hit_reg <= 1'b0;
        end else begin
            if (req.clr) begin
                vld_reg <= '0;
            end else if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en) begin
                qv_reg      <= vld_reg[req.rd_addr];
                // same-edge write to the entry being read
                byp_hit_reg <= req.wr_en && !req.clr && (req.wr_addr == req.rd_addr);
            end
        end
    end

    // entries never written since the last clear read as zero
    assign rd_data = byp_hit_reg ? byp_data_reg : (qv_reg ? q_reg : '0);

endmodule

@@ src/prf_par_ram.sv @@
`timescale 1ns / 1ps
// parent store: synchronous ram, one write and one registered read port
// depends on prf_pkg
module prf_par_ram
    import prf_pkg::*;
(
    input  logic             aclk,
    input  par_req_t         req,
    output logic [IDX_W-1:0] rd_data
);

    logic [IDX_W-1:0] mem [NODE_SLOTS];
    logic [IDX_W-1:0] q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

@@ src/prf_ctrl.sv @@
`timescale 1ns / 1ps
// sequencer: loads the parent array, then scans for leaves and emits the code
// depends on prf_pkg
module prf_ctrl
    import prf_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    output deg_req_t         deg_req,
    input  logic [DEG_W-1:0] deg_rd,
    output par_req_t         par_req,
    input  logic [IDX_W-1:0] par_rd
);

    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int CW    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LD1  = 3'd1;
    localparam logic [2:0] ST_LD2  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_CHK  = 3'd4;
    localparam logic [2:0] ST_PAR  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0] node_reg, node_next;
    logic [IDX_W-1:0] par_reg, par_next;
    logic             upd_reg, upd_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             jmp_reg, jmp_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        out_reg, out_next;

    logic             accept;
    logic             load_out;
    logic [IDX_W-1:0] entry;
    logic [IDX_W-1:0] rd_idx;
    logic [DEG_W-1:0] p_deg;

    assign s_ready = (state_reg == ST_IDLE) || (state_reg == ST_LD2 && !last_reg);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign rd_idx  = jmp_reg ? cur_reg : IDX_W'(ptr_reg);
    assign p_deg   = deg_dec(deg_rd);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        root_next    = root_reg;
        node_next    = node_reg;
        par_next     = par_reg;
        upd_next     = upd_reg;
        last_next    = last_reg;
        ptr_next     = ptr_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        jmp_next     = jmp_reg;
        p_next       = p_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        deg_req      = '0;
        par_req      = '0;
        load_out     = 1'b0;
        entry        = root_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_LD1: begin
                if (upd_reg) begin
                    deg_req.wr_en   = 1'b1;
                    deg_req.wr_addr = node_reg;
                    deg_req.wr_data = deg_inc(deg_rd);
                end
                deg_req.rd_en   = 1'b1;
                deg_req.rd_addr = par_reg;
                state_next      = ST_LD2;
            end
            ST_LD2: begin
                if (upd_reg) begin
                    deg_req.wr_en   = 1'b1;
                    deg_req.wr_addr = par_reg;
                    deg_req.wr_data = deg_inc(deg_rd);
                end
                if (last_reg) begin
                    if (cnt_reg < CNT_W'(2)) begin
                        cnt_next    = '0;
                        root_next   = '0;
                        deg_req.clr = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        ptr_next   = '0;
                        k_next     = '0;
                        jmp_next   = 1'b0;
                        state_next = ST_RD;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD: begin
                if (!jmp_reg && ptr_reg >= cnt_reg) begin
                    // no leaf left: entry is the root, nothing removed
                    entry    = root_reg;
                    load_out = 1'b1;
                end else begin
                    cur_next        = rd_idx;
                    deg_req.rd_en   = 1'b1;
                    deg_req.rd_addr = rd_idx;
                    par_req.rd_en   = 1'b1;
                    par_req.rd_addr = rd_idx;
                    state_next      = ST_CHK;
                end
            end
            ST_CHK: begin
                jmp_next = 1'b0;
                if (cur_reg != root_reg && deg_rd == DEG_W'(1)) begin
                    deg_req.wr_en   = 1'b1;
                    deg_req.wr_addr = cur_reg;
                    deg_req.wr_data = deg_dec(deg_rd);
                    deg_req.rd_en   = 1'b1;
                    deg_req.rd_addr = par_rd;
                    p_next          = par_rd;
                    if (!jmp_reg) begin
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                    state_next = ST_PAR;
                end else begin
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_PAR: begin
                deg_req.wr_en   = 1'b1;
                deg_req.wr_addr = p_reg;
                deg_req.wr_data = p_deg;
                entry           = p_reg;
                load_out        = 1'b1;
                cur_next        = p_reg;
                // parent below the scan point just became a leaf: it is the next one
                jmp_next = (CW'(p_reg) < CW'(ptr_reg)) && (p_reg != root_reg)
                           && (p_deg == DEG_W'(1));
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    k_next       = k_reg + CNT_W'(1);
                    if (out_reg.last_entry) begin
                        cnt_next    = '0;
                        root_next   = '0;
                        deg_req.clr = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            m_valid_next        = 1'b1;
            out_next.code_entry = entry;
            out_next.last_entry = ((CNT_W+1)'(k_reg) + (CNT_W+1)'(2))
                                  == (CNT_W+1)'(cnt_reg);
            state_next          = ST_OUT;
        end

        if (accept) begin
            node_next = IDX_W'(cnt_reg);
            par_next  = s_data.parent_index;
            last_next = s_data.last_node;
            upd_next  = (cnt_reg < CNT_W'(MAX_NODES)) && !s_data.is_root;
            if (cnt_reg < CNT_W'(MAX_NODES)) begin
                cnt_next        = cnt_reg + CNT_W'(1);
                par_req.wr_en   = 1'b1;
                par_req.wr_addr = IDX_W'(cnt_reg);
                par_req.wr_data = s_data.is_root ? '0 : s_data.parent_index;
                if (s_data.is_root) begin
                    root_next = IDX_W'(cnt_reg);
                end
            end
            deg_req.rd_en   = 1'b1;
            deg_req.rd_addr = IDX_W'(cnt_reg);
            state_next      = ST_LD1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            root_reg    <= '0;
            upd_reg     <= 1'b0;
            last_reg    <= 1'b0;
            jmp_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            root_reg    <= root_next;
            upd_reg     <= upd_next;
            last_reg    <= last_next;
            jmp_reg     <= jmp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg <= node_next;
        par_reg  <= par_next;
        ptr_reg  <= ptr_next;
        k_reg    <= k_next;
        cur_reg  <= cur_next;
        p_reg    <= p_next;
        out_reg  <= out_next;
    end

endmodule

@@ src/prf_checker.sv @@
`timescale 1ns / 1ps
// port-level checks for the prufer code block, bound to the top level
// depends on prf_pkg and prufer_code_from_parent_array_top
module prf_checker
    import prf_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no request is taken while code entries are being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during emission");

    // the loader never takes requests back to back
    a_load_pace: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken on back-to-back cycles");

    // the final entry ends the run
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_entry |=> !m_valid)
        else $error("result after the final entry");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind prufer_code_from_parent_array_top prf_checker u_prf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
